// ===== rtl/core/wfd_pkg.sv =====
// Package with the shared constants and types of the waveform frame deframer.
`timescale 1ns / 1ps

package wfd_pkg;

	// Frame layout.
	localparam int unsigned PAIRS_PER_FRAME = 50;
	localparam int unsigned TRAILER_BYTES   = 8;

	localparam logic [7:0] SYNC_FIRST  = 8'h90;
	localparam logic [7:0] SYNC_SECOND = 8'hEB;

	// Field widths.
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned INDEX_W  = 6;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned TRIG_W   = 8;
	localparam int unsigned CNT_W    = 8;
	localparam int unsigned TDATA_W  = 48;

	// Bytes of one sample pair that are held before the fourth one arrives.
	localparam int unsigned PART_BYTES = 3;

	// Parser phases, one-hot.
	typedef enum logic [5:0] {
		PH_HUNT    = 6'b000001,
		PH_SYNC2   = 6'b000010,
		PH_ID      = 6'b000100,
		PH_MODE    = 6'b001000,
		PH_DATA    = 6'b010000,
		PH_TRAILER = 6'b100000
	} wfd_phase_t;

	// One completed sample pair.
	typedef struct packed {
		logic [INDEX_W-1:0]  sample_index;
		logic [SAMPLE_W-1:0] left_sample;
		logic [SAMPLE_W-1:0] right_sample;
		logic [TRIG_W-1:0]   trigger_id;
		logic                last_of_frame;
	} wfd_result_t;

endpackage

// ===== rtl/core/wfd_in_stage.sv =====
// Input register that holds one stream byte in front of the parser.
`timescale 1ns / 1ps

module wfd_in_stage
	import wfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,
	input  logic              step,
	output logic              byte_valid,
	output logic [BYTE_W-1:0] data_byte
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// A new transaction is taken when the stage is empty or is being drained.
	assign s_tready = !valid_s1 || step;

	// Valid flag of the held byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Byte payload, loaded on every accepted transaction.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	assign byte_valid = valid_s1;
	assign data_byte  = byte_s1;

endmodule

// ===== rtl/core/wfd_parser.sv =====
// Frame parser: sync hunt, header checks, sample pair assembly and trailer skip.
`timescale 1ns / 1ps

module wfd_parser
	import wfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [BYTE_W-1:0] cfg_wr_data,
	input  logic              step,
	input  logic [BYTE_W-1:0] data_byte,
	output logic              res_valid,
	output wfd_result_t       res
);

	localparam logic [CNT_W-1:0] LAST_PAIR   = CNT_W'(PAIRS_PER_FRAME - 1);
	localparam logic [CNT_W-1:0] LAST_TRAIL  = CNT_W'((TRAILER_BYTES > 0) ? TRAILER_BYTES - 1 : 0);
	localparam bit               HAS_TRAILER = (TRAILER_BYTES > 0);

	wfd_phase_t              phase_q;
	wfd_phase_t              phase_d;
	logic [BYTE_W-1:0]       frame_mode_q;
	logic [BYTE_W-1:0]       trig_q;
	logic [1:0]              byte_pos_q;
	logic [CNT_W-1:0]        pair_cnt_q;
	logic [CNT_W-1:0]        trail_cnt_q;
	logic [BYTE_W*PART_BYTES-1:0] part_q;
	logic                    pair_done;
	logic                    last_pair;
	logic [CNT_W-1:0]        pair_next;

	// Mode register, written from the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode_q <= '0;
		end else if (cfg_wr_en) begin
			frame_mode_q <= cfg_wr_data;
		end
	end

	// The fourth byte of a pair completes it.
	assign pair_done = (phase_q == PH_DATA) && (byte_pos_q == 2'(PART_BYTES));
	assign last_pair = (pair_cnt_q == LAST_PAIR);
	assign pair_next = pair_cnt_q + CNT_W'(1);

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_HUNT: begin
				if (data_byte == SYNC_FIRST) phase_d = PH_SYNC2;
			end
			PH_SYNC2: begin
				phase_d = (data_byte == SYNC_SECOND) ? PH_ID : PH_HUNT;
			end
			PH_ID: begin
				phase_d = PH_MODE;
			end
			PH_MODE: begin
				phase_d = (data_byte == frame_mode_q) ? PH_DATA : PH_HUNT;
			end
			PH_DATA: begin
				if (pair_done && last_pair) phase_d = HAS_TRAILER ? PH_TRAILER : PH_HUNT;
			end
			PH_TRAILER: begin
				if (trail_cnt_q == LAST_TRAIL) phase_d = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	// Control state, advanced once per consumed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			byte_pos_q  <= '0;
			pair_cnt_q  <= '0;
			trail_cnt_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			if (phase_q == PH_MODE) begin
				byte_pos_q <= '0;
				pair_cnt_q <= '0;
			end else if (phase_q == PH_DATA) begin
				if (pair_done) begin
					byte_pos_q <= '0;
					pair_cnt_q <= last_pair ? '0 : pair_next;
				end else begin
					byte_pos_q <= byte_pos_q + 2'd1;
				end
			end
			if (phase_q == PH_TRAILER) begin
				trail_cnt_q <= (trail_cnt_q == LAST_TRAIL) ? '0 : trail_cnt_q + CNT_W'(1);
			end
		end
	end

	// Header ID and the first three bytes of the current pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q <= '0;
			part_q <= '0;
		end else if (step) begin
			if (phase_q == PH_ID) begin
				trig_q <= data_byte;
			end
			if (phase_q == PH_DATA && !pair_done) begin
				case (byte_pos_q)
					2'd0:    part_q[7:0]   <= data_byte;
					2'd1:    part_q[15:8]  <= data_byte;
					2'd2:    part_q[23:16] <= data_byte;
					default: part_q        <= part_q;
				endcase
			end
		end
	end

	// Result of a completed pair.
	assign res_valid         = step && pair_done;
	assign res.sample_index  = pair_next[INDEX_W-1:0];
	assign res.left_sample   = part_q[15:0];
	assign res.right_sample  = {data_byte, part_q[23:16]};
	assign res.trigger_id    = trig_q;
	assign res.last_of_frame = last_pair;

`ifndef SYNTHESIS
	a_pair_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		pair_cnt_q <= LAST_PAIR)
		else $error("pair counter ran past the frame length");

	a_trail_idle: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_TRAILER |-> trail_cnt_q == '0)
		else $error("trailer counter not cleared outside the trailer");

	a_mode_reject: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_MODE && data_byte != frame_mode_q |=> phase_q == PH_HUNT)
		else $error("mode mismatch did not return to hunting");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last_of_frame |=> (phase_q == PH_TRAILER || phase_q == PH_HUNT)
			&& pair_cnt_q == '0)
		else $error("frame did not close after its last pair");
`endif

endmodule

// ===== rtl/core/wfd_out_reg.sv =====
// Output register that holds one result transaction for the master side.
`timescale 1ns / 1ps

module wfd_out_reg
	import wfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  wfd_result_t        res,
	output logic               room,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,
	output logic               m_tlast
);

	logic        valid_q;
	wfd_result_t res_q;

	// Free when empty or when the held transaction leaves this cycle.
	assign room = !valid_q || m_tready;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	// Pack the fields, first field lowest, padded to whole bytes.
	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, res_q.trigger_id, res_q.right_sample,
	                   res_q.left_sample, res_q.sample_index};
	assign m_tlast  = res_q.last_of_frame;

endmodule

// ===== rtl/core/waveform_frame_deframer.sv =====
// Top level of the waveform frame deframer.
//
//   Channel  Dir  Payload
//   s_*      in   tdata[7:0] data_byte
//   m_*      out  tdata[5:0] sample_index, [21:6] left_sample, [37:22] right_sample,
//                 [45:38] trigger_id, [47:46] zero; tlast last_of_frame
//   cfg_*    in   cfg_wr_data frame_mode
//
// One byte per cycle is sustained while the master keeps up; a byte passes the
// input register and the parser, and each result is registered for the master side.
// Reset returns the parser to hunting for the first sync byte and clears frame_mode.
// A stalled master side stops the parser only once the output register is full.
`timescale 1ns / 1ps

module waveform_frame_deframer
	import wfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [BYTE_W-1:0]  s_tdata,   // data_byte
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // sample_index, left, right, trigger_id, pad
	output logic               m_tlast,
	input  logic               cfg_wr_en,
	input  logic [BYTE_W-1:0]  cfg_wr_data
);

	logic              byte_valid;
	logic [BYTE_W-1:0] data_byte;
	logic              room;
	logic              step;
	logic              res_valid;
	wfd_result_t       res;

	// The held byte moves into the parser whenever a result could be stored.
	assign step = byte_valid && room;

	wfd_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.step       (step),
		.byte_valid (byte_valid),
		.data_byte  (data_byte)
	);

	wfd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (step),
		.data_byte   (data_byte),
		.res_valid   (res_valid),
		.res         (res)
	);

	wfd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_valid),
		.res      (res),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== test/tb_waveform_frame_deframer.sv =====
// Testbench for the waveform frame deframer: byte stream in, sample pairs out, self-checking.
`timescale 1ns / 1ps

module tb_waveform_frame_deframer;
	import wfd_pkg::*;

	localparam int unsigned HALF_PERIOD   = 10;
	localparam int unsigned DRAIN_CYCLES  = 8;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned IDLE_PERCENT  = 21;
	localparam int unsigned RANDOM_BYTES  = 100;
	localparam int unsigned REPORT_LIMIT  = 10;
	localparam int unsigned FINAL_WAIT    = 2000;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [BYTE_W-1:0]  s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tlast;
	logic               cfg_wr_en;
	logic [BYTE_W-1:0]  cfg_wr_data;

	// Local copy of the parser state and the mode register.
	wfd_phase_t         model_phase = PH_HUNT;
	logic [BYTE_W-1:0]  model_mode  = '0;
	logic [CNT_W-1:0]   model_pos   = '0;
	logic [CNT_W-1:0]   model_pairs = '0;
	logic [23:0]        model_part  = '0;
	logic [TRIG_W-1:0]  model_trig  = '0;

	wfd_result_t        pending_pairs[$];
	int unsigned        mismatches  = 0;
	int unsigned        bytes_sent  = 0;
	bit                 no_idle     = 1'b0;
	bit                 hold_request = 1'b0;

	waveform_frame_deframer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #(HALF_PERIOD) clk = ~clk;
	end

	// Advance the parser copy by one accepted byte and queue any completed pair.
	function automatic void parse_byte(input logic [BYTE_W-1:0] b);
		wfd_result_t r;
		case (model_phase)
			PH_HUNT: begin
				if (b == SYNC_FIRST) model_phase = PH_SYNC2;
			end
			PH_SYNC2: begin
				// The byte after the first sync byte is always consumed.
				model_phase = (b == SYNC_SECOND) ? PH_ID : PH_HUNT;
			end
			PH_ID: begin
				model_trig  = b;
				model_phase = PH_MODE;
			end
			PH_MODE: begin
				if (b == model_mode) begin
					model_phase = PH_DATA;
					model_pos   = '0;
					model_pairs = '0;
					model_part  = '0;
				end else begin
					model_phase = PH_HUNT;
				end
			end
			PH_DATA: begin
				if (model_pos < PART_BYTES) begin
					model_part = model_part | (24'(b) << (8 * model_pos));
					model_pos  = model_pos + 1'b1;
				end else begin
					r.sample_index  = INDEX_W'(model_pairs + 1'b1);
					r.left_sample   = model_part[15:0];
					r.right_sample  = {b, model_part[23:16]};
					r.trigger_id    = model_trig;
					r.last_of_frame = (32'(model_pairs) + 1 >= PAIRS_PER_FRAME);
					pending_pairs.push_back(r);
					model_part = '0;
					model_pos  = '0;
					if (r.last_of_frame) begin
						model_pairs = '0;
						model_phase = (TRAILER_BYTES > 0) ? PH_TRAILER : PH_HUNT;
					end else begin
						model_pairs = model_pairs + 1'b1;
					end
				end
			end
			PH_TRAILER: begin
				model_pos = model_pos + 1'b1;
				if (model_pos >= TRAILER_BYTES) begin
					model_pos   = '0;
					model_phase = PH_HUNT;
				end
			end
			default: model_phase = PH_HUNT;
		endcase
	endfunction

	// Compare one output transaction with the oldest expected pair.
	task automatic check_pair(input logic [TDATA_W-1:0] data, input logic last);
		wfd_result_t got;
		wfd_result_t want;
		got.sample_index  = data[5:0];
		got.left_sample   = data[21:6];
		got.right_sample  = data[37:22];
		got.trigger_id    = data[45:38];
		got.last_of_frame = last;
		if (pending_pairs.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: unexpected pair idx=%0d l=%h r=%h id=%h last=%b",
					$realtime, got.sample_index, got.left_sample, got.right_sample,
					got.trigger_id, got.last_of_frame);
		end else begin
			want = pending_pairs.pop_front();
			if (got !== want || data[47:46] !== 2'b00) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%0t: pair mismatch exp idx=%0d l=%h r=%h id=%h last=%b pad=0",
						$realtime, want.sample_index, want.left_sample,
						want.right_sample, want.trigger_id, want.last_of_frame);
					$display("%0t: pair mismatch got idx=%0d l=%h r=%h id=%h last=%b pad=%b",
						$realtime, got.sample_index, got.left_sample,
						got.right_sample, got.trigger_id, got.last_of_frame,
						data[47:46]);
				end
			end
		end
	endtask

	// Master side: check each transaction and drive tready, with random stalls and one long hold.
	initial begin : receiver
		int unsigned hold_left;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) check_pair(m_tdata, m_tlast);
			if (hold_request && hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_request <= 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (no_idle) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	// Offer one byte, with an occasional idle cycle in front, and wait for the transaction.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		if (!no_idle && $urandom_range(99) < IDLE_PERCENT + 4) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		parse_byte(b);
		bytes_sent++;
	endtask

	// Stop offering and wait until every expected pair has arrived and the pipeline is empty.
	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		while (pending_pairs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic [BYTE_W-1:0] m);
		drain_pipeline();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		model_mode = m;
	endtask

	// Feed filler bytes until the parser is back to hunting for sync.
	task automatic resync();
		logic [BYTE_W-1:0] b;
		while (model_phase != PH_HUNT) begin
			b = 8'($urandom);
			if (b == SYNC_FIRST) b = 8'h00;
			send_byte(b);
		end
	endtask

	task automatic send_header(input logic [TRIG_W-1:0] trig, input logic [BYTE_W-1:0] mode);
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_byte(trig);
		send_byte(mode);
	endtask

	// A whole frame; the extreme form opens with all-zero and all-one samples and a trailer
	// that looks like a sync pair.
	task automatic send_frame(input logic [TRIG_W-1:0] trig, input logic [BYTE_W-1:0] mode,
			input bit extreme);
		logic [SAMPLE_W-1:0] left;
		logic [SAMPLE_W-1:0] right;
		logic [BYTE_W-1:0]   b;
		send_header(trig, mode);
		for (int i = 0; i < PAIRS_PER_FRAME; i++) begin
			left  = 16'($urandom);
			right = 16'($urandom);
			if (extreme && i < 4) begin
				left  = i[0] ? 16'hFFFF : 16'h0000;
				right = i[1] ? left : ~left;
			end
			send_byte(left[7:0]);
			send_byte(left[15:8]);
			send_byte(right[7:0]);
			send_byte(right[15:8]);
		end
		for (int i = 0; i < TRAILER_BYTES; i++) begin
			b = 8'($urandom);
			if (extreme) b = i[0] ? SYNC_SECOND : SYNC_FIRST;
			send_byte(b);
		end
	endtask

	// Sync corner cases and a mode mismatch with the mode register at its reset value.
	task automatic test_sync_cases();
		// A repeated first sync byte is eaten as the bad second byte.
		send_byte(SYNC_FIRST);
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_byte(8'h07);
		send_byte(8'h00);
		// Correct sync but the wrong mode.
		send_header(8'h33, 8'h01);
		send_byte(8'h00);
		// A matching header and one pair with extreme values.
		send_header(8'h00, 8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hFF);
	endtask

	// Two complete frames back to back at full rate on both sides.
	task automatic test_full_frames();
		resync();
		no_idle = 1'b1;
		send_frame(8'hFF, model_mode, 1'b1);
		send_frame(8'h00, model_mode, 1'b1);
		no_idle = 1'b0;
	endtask

	// Each mode setting with one matching frame and one rejected header.
	task automatic test_mode_sweep();
		logic [BYTE_W-1:0] modes[2];
		logic [BYTE_W-1:0] other;
		modes = '{8'hFF, SYNC_FIRST};
		foreach (modes[i]) begin
			write_mode(modes[i]);
			resync();
			send_frame(8'($urandom), modes[i], 1'b0);
			other = modes[i] ^ 8'($urandom_range(1, 255));
			send_header(8'($urandom), other);
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
		end
	endtask

	// The receiver holds off for a long stretch while a frame keeps being offered.
	task automatic test_backpressure();
		resync();
		no_idle = 1'b1;
		hold_request <= 1'b1;
		send_frame(8'($urandom), model_mode, 1'b0);
		no_idle = 1'b0;
	endtask

	// Mostly well-formed frames with random content, mixed with noise and broken sequences.
	task automatic test_random_stream();
		int unsigned start;
		int unsigned pick;
		logic [BYTE_W-1:0] b;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			pick = $urandom_range(99);
			if (pick < 5) begin
				write_mode(8'($urandom));
			end else if (pick < 65) begin
				resync();
				send_frame(8'($urandom), model_mode, 1'b0);
			end else if (pick < 75) begin
				// Noise rich in sync bytes.
				repeat ($urandom_range(1, 20)) begin
					case ($urandom_range(2))
						0: b = SYNC_FIRST;
						1: b = SYNC_SECOND;
						default: b = 8'($urandom);
					endcase
					send_byte(b);
				end
			end else if (pick < 85) begin
				// Broken header: wrong second sync byte or wrong mode.
				send_byte(SYNC_FIRST);
				if ($urandom_range(1)) begin
					b = 8'($urandom);
					if (b == SYNC_SECOND) b = SYNC_FIRST;
					send_byte(b);
				end else begin
					send_byte(SYNC_SECOND);
					send_byte(8'($urandom));
					send_byte(model_mode ^ 8'($urandom_range(1, 255)));
				end
			end else begin
				// A frame cut short; the following bytes land in its data.
				resync();
				send_header(8'($urandom), model_mode);
				repeat ($urandom_range(0, 120)) send_byte(8'($urandom));
			end
		end
	endtask

	// Reset, then the tests in turn, then the final verdict.
	initial begin
		arst_n      <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sync_cases();
		test_full_frames();
		test_mode_sweep();
		test_backpressure();
		test_random_stream();

		s_tvalid <= 1'b0;
		for (int i = 0; i < FINAL_WAIT && pending_pairs.size() != 0; i++) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatches += pending_pairs.size();
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog well beyond the slowest correct run.
	initial begin
		#(10_000_000);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
